/* rtl/core/ptt_pkg.sv */
// shared types and constants of the timer table
`default_nettype none
package ptt_pkg;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_KILL   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] RK_CREATE = 2'd0;
    localparam logic [1:0] RK_KILL   = 2'd1;
    localparam logic [1:0] RK_FIRE   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] FK_CALLBACK = 2'd0;
    localparam logic [1:0] FK_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_time;
        logic [31:0] delay_ticks;
        logic [1:0]  fire_kind;
        logic        periodic;
        logic [31:0] callback_ref;
        logic [31:0] user_word;
        logic [31:0] target_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [31:0] timer_id;
        logic [1:0]  status;
        logic [1:0]  fired_kind;
        logic [31:0] fired_ref;
        logic [31:0] fired_user;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] delay;
        logic [31:0] prev_time;
        logic [31:0] overshoot;
        logic [31:0] ref_word;
        logic [31:0] user;
        logic [1:0]  kind;
        logic        periodic;
    } slot_t;

    // id = 11 * counter, as shifts and adds
    function automatic logic [31:0] id_of(input logic [31:0] cnt);
        id_of = (cnt << 3) + (cnt << 1) + cnt;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/ptt_ram.sv */
// generic single-write, single-read ram with registered read
`default_nettype none
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/ptt_front.sv */
// front end: accepts transactions, cleans them up and queues them
`default_nettype none
module ptt_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire ptt_pkg::req_t req,
    output logic              cmd_valid,
    output ptt_pkg::req_t     cmd,
    input  wire logic         cmd_pop
);
    import ptt_pkg::*;

    req_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    req_t       clean;

    assign req_ready = (cnt_reg != 2'd2);
    // unused opcode is taken and dropped
    assign push = req_valid && req_ready && (req.opcode != OP_UNUSED);

    always_comb
    begin
        clean = req;
        if (req.fire_kind == FK_UNUSED)
        begin
            clean.fire_kind = FK_CALLBACK;
        end
    end

    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= clean;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end
endmodule
`default_nettype wire

/* rtl/core/ptt_back.sv */
// back end: timer table, create/kill/tick sequencer and result register
`default_nettype none
module ptt_back #(
    parameter int SLOTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          mode,
    input  wire logic          cmd_valid,
    input  wire ptt_pkg::req_t cmd,
    output logic               cmd_pop,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output ptt_pkg::rsp_t      rsp
);
    import ptt_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RD    = 4'b0010,
        S_EV    = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    fill_reg, fill_next;
    req_t             cmd_reg, cmd_next;
    logic [31:0]      id_cnt_reg, id_cnt_next;
    rsp_t             pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    rsp_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic [SLOTS-1:0] killed_reg, killed_next;

    logic             we;
    logic [IW-1:0]    waddr;
    slot_t            wdata, rd_slot;
    logic             out_free, at_end, fire, stall;
    logic [31:0]      elapsed, need;

    ptt_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rd_slot)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign at_end    = ((CW'(idx_reg) + CW'(1)) == fill_reg);

    assign elapsed = cmd_reg.now_time - rd_slot.prev_time;
    assign need    = rd_slot.delay - rd_slot.overshoot;
    assign fire    = ($signed(elapsed) >= $signed(need));
    // a second fire cannot be held until the older one moves out
    assign stall   = fire && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        fill_next       = fill_reg;
        cmd_next        = cmd_reg;
        id_cnt_next     = id_cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        killed_next     = killed_reg;
        cmd_pop         = 1'b0;
        we              = 1'b0;
        waddr           = j_reg[IW-1:0];
        wdata           = rd_slot;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    cmd_next  = cmd;
                    idx_next  = '0;
                    j_next    = '0;
                    pend_next = '{reply_kind: RK_CREATE, timer_id: 32'd0, status: ST_OK,
                                  fired_kind: FK_CALLBACK, fired_ref: 32'd0,
                                  fired_user: 32'd0, last: 1'b1};
                    case (cmd.opcode)
                        OP_CREATE:
                        begin
                            pend_valid_next = 1'b1;
                            state_next      = S_FLUSH;
                            if (!mode)
                            begin
                                id_cnt_next        = id_cnt_reg + 32'd1;
                                pend_next.timer_id = id_of(id_cnt_reg + 32'd1);
                            end
                            else if (fill_reg == CW'(SLOTS))
                            begin
                                pend_next.status = ST_FULL;
                            end
                            else
                            begin
                                id_cnt_next        = id_cnt_reg + 32'd1;
                                pend_next.timer_id = id_of(id_cnt_reg + 32'd1);
                                we                 = 1'b1;
                                waddr              = fill_reg[IW-1:0];
                                wdata = '{id: id_of(id_cnt_reg + 32'd1),
                                          delay: cmd.delay_ticks,
                                          prev_time: cmd.now_time, overshoot: 32'd0,
                                          ref_word: cmd.callback_ref, user: cmd.user_word,
                                          kind: cmd.fire_kind, periodic: cmd.periodic};
                                killed_next[fill_reg[IW-1:0]] = 1'b0;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        OP_KILL:
                        begin
                            pend_next.reply_kind = RK_KILL;
                            pend_next.timer_id   = cmd.target_id;
                            if (fill_reg == '0)
                            begin
                                pend_next.status = mode ? ST_INVALID : ST_OK;
                                pend_valid_next  = 1'b1;
                                state_next       = S_FLUSH;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_TICK:
                        begin
                            if (fill_reg != '0)
                            begin
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_EV;
            end

            S_EV:
            begin
                if (cmd_reg.opcode == OP_KILL)
                begin
                    if (rd_slot.id == cmd_reg.target_id)
                    begin
                        killed_next[idx_reg] = 1'b1;
                        pend_next.status     = ST_OK;
                        pend_valid_next      = 1'b1;
                        state_next           = S_FLUSH;
                    end
                    else if (at_end)
                    begin
                        pend_next.status = mode ? ST_INVALID : ST_OK;
                        pend_valid_next  = 1'b1;
                        state_next       = S_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
                else if (!stall)
                begin
                    // live entries are packed down to position j
                    if (!killed_reg[idx_reg])
                    begin
                        we = 1'b1;
                        if (fire)
                        begin
                            wdata.overshoot = rd_slot.overshoot + elapsed - rd_slot.delay;
                            wdata.prev_time = cmd_reg.now_time;
                            if (pend_valid_reg)
                            begin
                                out_next       = pend_reg;
                                out_next.last  = 1'b0;
                                out_valid_next = 1'b1;
                            end
                            pend_valid_next = 1'b1;
                            pend_next = '{reply_kind: RK_FIRE, timer_id: rd_slot.id,
                                          status: ST_OK, fired_kind: rd_slot.kind,
                                          fired_ref: rd_slot.ref_word,
                                          fired_user: rd_slot.user, last: 1'b1};
                        end
                        killed_next[j_reg[IW-1:0]] = fire && !rd_slot.periodic;
                        j_next = j_reg + CW'(1);
                    end
                    if (at_end)
                    begin
                        fill_next  = killed_reg[idx_reg] ? j_reg : j_reg + CW'(1);
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            j_reg          <= '0;
            fill_reg       <= '0;
            id_cnt_reg     <= 32'd1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            killed_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            j_reg          <= j_next;
            fill_reg       <= fill_next;
            id_cnt_reg     <= id_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            killed_reg     <= killed_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/periodic_timer_table_drift_corrected.sv */
// Table of up to SLOTS software timers with drift-corrected periodic firing.
// Request channel req_valid/req_ready/req carries create, kill and tick
// transactions; response channel rsp_valid/rsp_ready/rsp returns one reply
// for create and kill and one fire per expiring timer for tick, the last
// result of a transaction flagged by rsp.last. A tick that fires nothing
// and an unused opcode give no result.
// Requests enter a two-entry queue, so up to two wait while the back end
// works. A create reply is held pending, then moved to the output register.
// Kill and tick walk the table one entry at a time (table ram read, then
// evaluate and write back); a tick visits every stored timer, marked ones
// included, and a kill stops at the matching entry.
// A stalled receiver holds one result in the output register and one
// more fire pending; the walk then waits until the output drains.
// Reset empties the table, sets the id counter to one and the mode to
// emulate; no clearing pass is needed. cfg_we/cfg_wdata write the mode
// (0 suppress, 1 emulate) while the block is idle.
`default_nettype none
module periodic_timer_table_drift_corrected #(
    parameter int SLOTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ptt_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output ptt_pkg::rsp_t      rsp,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata
);
    import ptt_pkg::*;

    logic mode_reg;
    logic cmd_valid, cmd_pop;
    req_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    ptt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ptt_back #(.SLOTS(SLOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );
endmodule
`default_nettype wire

/* test/periodic_timer_table_drift_corrected_tb.sv */
// testbench for the timer table: directed table, random traffic, scoreboard against a model
`default_nettype none
module periodic_timer_table_drift_corrected_tb;
    import ptt_pkg::*;

    localparam int NSLOT = 16;
    localparam int RAND_ITEMS = 70;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    logic cfg_we;
    logic cfg_wdata;

    periodic_timer_table_drift_corrected #(.SLOTS(NSLOT)) u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // timer table mirror
    logic        tm_mode;
    logic        tm_valid   [NSLOT];
    logic        tm_killed  [NSLOT];
    logic [31:0] tm_id      [NSLOT];
    logic [31:0] tm_delay   [NSLOT];
    logic [31:0] tm_prev    [NSLOT];
    logic [31:0] tm_over    [NSLOT];
    logic [1:0]  tm_kind    [NSLOT];
    logic        tm_periodic[NSLOT];
    logic [31:0] tm_ref     [NSLOT];
    logic [31:0] tm_user    [NSLOT];
    logic [31:0] id_count;

    rsp_t pending_replies[$];
    int   errors;
    int   replies_seen;
    int   fires_seen;
    int   items_sent;
    longint cycles;
    bit   hold_rsp;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic rsp_t make_reply(logic [1:0] kind, logic [31:0] id, logic [1:0] st,
                                        logic [1:0] fk, logic [31:0] rf, logic [31:0] us);
        rsp_t r;
        r.reply_kind = kind;
        r.timer_id   = id;
        r.status     = st;
        r.fired_kind = fk;
        r.fired_ref  = rf;
        r.fired_user = us;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic void clear_entry(int i);
        tm_valid[i] = '0; tm_killed[i] = '0; tm_id[i] = '0; tm_delay[i] = '0;
        tm_prev[i] = '0; tm_over[i] = '0; tm_kind[i] = '0; tm_periodic[i] = '0;
        tm_ref[i] = '0; tm_user[i] = '0;
    endfunction

    function automatic void table_reset();
        tm_mode = 1'b1;
        for (int i = 0; i < NSLOT; i++)
            clear_entry(i);
        id_count = 32'd1;
    endfunction

    // applies one transaction to the mirror and queues the replies it causes
    function automatic void predict_timer_op(req_t q);
        rsp_t out[$];
        logic [1:0] kind;
        logic [1:0] st;
        logic [31:0] elapsed;
        logic [31:0] need;
        int free_at;
        int j;
        free_at = -1;
        j = 0;
        if (q.opcode == OP_CREATE)
        begin
            kind = (q.fire_kind == FK_UNUSED) ? FK_CALLBACK : q.fire_kind;
            if (!tm_mode)
            begin
                id_count = id_count + 32'd1;
                out = {out, make_reply(RK_CREATE, id_count * 32'd11, ST_OK, FK_CALLBACK,
                                       32'd0, 32'd0)};
            end
            else
            begin
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!tm_valid[i])
                        free_at = i;
                if (free_at < 0)
                    out = {out, make_reply(RK_CREATE, 32'd0, ST_FULL, FK_CALLBACK,
                                           32'd0, 32'd0)};
                else
                begin
                    id_count = id_count + 32'd1;
                    tm_valid[free_at] = 1'b1;
                    tm_killed[free_at] = 1'b0;
                    tm_id[free_at] = id_count * 32'd11;
                    tm_delay[free_at] = q.delay_ticks;
                    tm_prev[free_at] = q.now_time;
                    tm_over[free_at] = 32'd0;
                    tm_kind[free_at] = kind;
                    tm_periodic[free_at] = q.periodic;
                    tm_ref[free_at] = q.callback_ref;
                    tm_user[free_at] = q.user_word;
                    out = {out, make_reply(RK_CREATE, tm_id[free_at], ST_OK, FK_CALLBACK,
                                           32'd0, 32'd0)};
                end
            end
        end
        else if (q.opcode == OP_KILL)
        begin
            st = tm_mode ? ST_INVALID : ST_OK;
            for (int i = 0; i < NSLOT; i++)
                if (tm_valid[i] && tm_id[i] == q.target_id && free_at < 0)
                begin
                    tm_killed[i] = 1'b1;
                    st = ST_OK;
                    free_at = i;
                end
            out = {out, make_reply(RK_KILL, q.target_id, st, FK_CALLBACK, 32'd0, 32'd0)};
        end
        else if (q.opcode == OP_TICK)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (tm_valid[i] && !tm_killed[i])
                begin
                    if (j != i)
                    begin
                        tm_valid[j] = tm_valid[i]; tm_killed[j] = tm_killed[i];
                        tm_id[j] = tm_id[i]; tm_delay[j] = tm_delay[i];
                        tm_prev[j] = tm_prev[i]; tm_over[j] = tm_over[i];
                        tm_kind[j] = tm_kind[i]; tm_periodic[j] = tm_periodic[i];
                        tm_ref[j] = tm_ref[i]; tm_user[j] = tm_user[i];
                    end
                    elapsed = q.now_time - tm_prev[j];
                    need = tm_delay[j] - tm_over[j];
                    if ($signed(elapsed) >= $signed(need))
                    begin
                        out = {out, make_reply(RK_FIRE, tm_id[j], ST_OK, tm_kind[j],
                                               tm_ref[j], tm_user[j])};
                        tm_over[j] = tm_over[j] + elapsed - tm_delay[j];
                        if (!tm_periodic[j])
                            tm_killed[j] = 1'b1;
                        tm_prev[j] = q.now_time;
                    end
                    j++;
                end
            end
            for (int i = j; i < NSLOT; i++)
                clear_entry(i);
        end
        if (out.size() > 0)
            out[out.size() - 1].last = 1'b1;
        foreach (out[k])
            pending_replies = {pending_replies, out[k]};
    endfunction

    // response checker
    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            replies_seen++;
            if (rsp.reply_kind == RK_FIRE)
                fires_seen++;
            if (pending_replies.size() == 0)
            begin
                $display("%0t unexpected reply %h", $time, rsp);
                errors++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                if (exp_r.reply_kind != rsp.reply_kind)
                begin
                    $display("%0t reply_kind exp %0d got %0d", $time, exp_r.reply_kind,
                             rsp.reply_kind);
                    errors++;
                end
                if (exp_r.timer_id != rsp.timer_id)
                begin
                    $display("%0t timer_id exp %h got %h", $time, exp_r.timer_id, rsp.timer_id);
                    errors++;
                end
                if (exp_r.status != rsp.status)
                begin
                    $display("%0t status exp %0d got %0d", $time, exp_r.status, rsp.status);
                    errors++;
                end
                if (exp_r.fired_kind != rsp.fired_kind)
                begin
                    $display("%0t fired_kind exp %0d got %0d", $time, exp_r.fired_kind,
                             rsp.fired_kind);
                    errors++;
                end
                if (exp_r.fired_ref != rsp.fired_ref)
                begin
                    $display("%0t fired_ref exp %h got %h", $time, exp_r.fired_ref,
                             rsp.fired_ref);
                    errors++;
                end
                if (exp_r.fired_user != rsp.fired_user)
                begin
                    $display("%0t fired_user exp %h got %h", $time, exp_r.fired_user,
                             rsp.fired_user);
                    errors++;
                end
                if (exp_r.last != rsp.last)
                begin
                    $display("%0t last exp %0d got %0d", $time, exp_r.last, rsp.last);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_rsp)
            rsp_ready <= 1'b0;
        else if ((cycles / 64) % 3 == 0)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        hold_rsp = 1'b0;
        wait (items_sent > 60);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // sends one transaction, with a random gap first in bursty fashion
    task automatic send_timer_op(req_t q, bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= q;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_timer_op(q);
        items_sent++;
    endtask

    task automatic drain_replies();
        req_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_mode(logic m);
        drain_replies();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        tm_mode = m;
    endtask

    function automatic req_t timer_op(logic [1:0] op, logic [31:0] now, logic [31:0] dly,
                                      logic [1:0] fk, logic per, logic [31:0] rf,
                                      logic [31:0] us, logic [31:0] tgt);
        req_t q;
        q.opcode = op; q.now_time = now; q.delay_ticks = dly; q.fire_kind = fk;
        q.periodic = per; q.callback_ref = rf; q.user_word = us; q.target_id = tgt;
        return q;
    endfunction

    function automatic req_t random_op(logic [31:0] now_base);
        req_t q;
        int pick;
        int sel;
        logic [31:0] tgt;
        q = timer_op(OP_TICK, $urandom(), $urandom(), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            q.opcode = OP_CREATE;
            if (pick < 30)
            begin
                q.now_time = now_base;
                q.delay_ticks = $urandom_range(0, 60);
            end
        end
        else if (pick < 50)
        begin
            q.opcode = OP_KILL;
            sel = $urandom_range(0, NSLOT - 1);
            tgt = 32'd11 * $urandom_range(1, id_count + 2);
            if (pick < 45 && tm_valid[sel])
                tgt = tm_id[sel];
            q.target_id = (pick < 48) ? tgt : $urandom();
        end
        else if (pick < 97)
        begin
            q.now_time = now_base + $urandom_range(0, 40);
            if (pick > 94)
                q.now_time = $urandom();
        end
        else
            q.opcode = OP_UNUSED;
        return q;
    endfunction

    // directed rows; expected reply filled only where obvious
    typedef struct {
        req_t q;
        bit   has_exp;
        rsp_t e;
    } dir_row_t;

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        logic [31:0] now_base;
        req_t q;
        rsp_t none;
        int n;
        none = '0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b1;
        errors = 0;
        replies_seen = 0;
        fires_seen = 0;
        items_sent = 0;
        cycles = 0;
        table_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: first create gets id 22, unknown kill is invalid
        row.q = timer_op(OP_CREATE, 32'd100, 32'd10, 2'd1, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'd0);
        row.has_exp = 1; row.e = make_reply(RK_CREATE, 32'd22, ST_OK, FK_CALLBACK, 32'd0, 32'd0);
        row.e.last = 1'b1; rows = {rows, row};
        row.q = timer_op(OP_KILL, 32'd0, 32'd0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd5);
        row.has_exp = 1; row.e = make_reply(RK_KILL, 32'd5, ST_INVALID, FK_CALLBACK, 32'd0, 32'd0);
        row.e.last = 1'b1; rows = {rows, row};
        row.has_exp = 0; row.e = none;
        row.q = timer_op(OP_CREATE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, FK_UNUSED, 1'b0, 32'h0,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF); rows = {rows, row};
        row.q = timer_op(OP_CREATE, 32'd0, 32'd0, 2'd2, 1'b0, 32'hA5A5_5A5A, 32'h1234_5678,
                         32'd0);
        rows = {rows, row};
        row.q = timer_op(OP_CREATE, 32'd100, 32'h8000_0000, 2'd0, 1'b1, 32'h5555_AAAA,
                         32'hAAAA_5555, 32'd0); rows = {rows, row};
        row.q = timer_op(OP_TICK, 32'd105, 32'd0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        rows = {rows, row};
        row.q = timer_op(OP_TICK, 32'd113, 32'd0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        rows = {rows, row};
        row.q = timer_op(OP_TICK, 32'd119, 32'd0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        rows = {rows, row};
        row.q = timer_op(OP_KILL, 32'd0, 32'd0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd22);
        rows = {rows, row};
        row.q = timer_op(OP_KILL, 32'd0, 32'd0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd22);
        rows = {rows, row};
        row.q = timer_op(OP_TICK, 32'hFFFF_FFFF, 32'd0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        rows = {rows, row};
        row.q = timer_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FK_UNUSED, 1'b1,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); rows = {rows, row};
        row.q = timer_op(OP_TICK, 32'h7FFF_FFFF, 32'd0, 2'd0, 1'b0, 32'd0, 32'd0, 32'd0);
        rows = {rows, row};
        foreach (rows[i])
        begin
            send_timer_op(rows[i].q, 0);
            if (rows[i].has_exp)
            begin
                n = pending_replies.size();
                if (n == 0 || pending_replies[n - 1] != rows[i].e)
                begin
                    $display("%0t directed row %0d expected %h", $time, i, rows[i].e);
                    errors++;
                end
            end
        end

        // fill the table to the brim; the creates beyond it are refused
        now_base = 32'd1000;
        for (int i = 0; i < NSLOT + 1; i++)
            send_timer_op(timer_op(OP_CREATE, now_base, $urandom_range(1, 30), 2'(i % 4),
                                   1'(i % 2), $urandom(), $urandom(), 32'd0), 1);
        if (pending_replies.size() == 0 ||
            pending_replies[pending_replies.size() - 1].status != ST_FULL)
        begin
            $display("%0t full table not reported, expected status %0d", $time, ST_FULL);
            errors++;
        end

        // pause until everything is back
        drain_replies();

        // suppressed mode: ids only, kills of unknown ids are ok
        set_mode(1'b0);
        for (int i = 0; i < 20; i++)
        begin
            now_base = now_base + $urandom_range(0, 20);
            send_timer_op(random_op(now_base), 1);
        end

        set_mode(1'b1);
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            now_base = now_base + $urandom_range(0, 15);
            send_timer_op(random_op(now_base), 1);
        end

        for (int i = 0; i < 10; i++)
        begin
            now_base = now_base + $urandom_range(0, 15);
            send_timer_op(random_op(now_base), 1);
        end

        drain_replies();
        $display("sent %0d transactions, checked %0d replies including %0d timer fires",
                 items_sent, replies_seen, fires_seen);
        if (errors == 0 && pending_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
